// ===== sv/pchip_sc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCHIP segment coefficients: shared package
// Datapath width, microcode format, operand codes and the microcode ROM.
// ----------------------------------------------------------------------------
package pchip_sc_pkg;

	localparam int DW  = 256;
	localparam int RA  = 5;
	localparam int PCW = 7;
	localparam int CW  = $clog2(DW);

	typedef logic [2:0]     op_t;
	typedef logic [RA-1:0]  ra_t;
	typedef logic [PCW-1:0] pc_t;

	localparam op_t OP_LD  = 3'd0;
	localparam op_t OP_ADD = 3'd1;
	localparam op_t OP_SUB = 3'd2;
	localparam op_t OP_MUL = 3'd3;
	localparam op_t OP_SHL = 3'd4;
	localparam op_t OP_CHK = 3'd5;
	localparam op_t OP_DIV = 3'd6;
	localparam op_t OP_END = 3'd7;

	// Scratch register addresses.
	localparam ra_t R_X0  = 5'd0;
	localparam ra_t R_Y0  = 5'd1;
	localparam ra_t R_X1  = 5'd2;
	localparam ra_t R_Y1  = 5'd3;
	localparam ra_t R_X2  = 5'd4;
	localparam ra_t R_Y2  = 5'd5;
	localparam ra_t R_D0  = 5'd6;
	localparam ra_t R_D1  = 5'd7;
	localparam ra_t R_H   = 5'd8;
	localparam ra_t R_H2  = 5'd9;
	localparam ra_t R_DY  = 5'd10;
	localparam ra_t R_DY2 = 5'd11;
	localparam ra_t R_H3  = 5'd12;
	localparam ra_t R_X02 = 5'd13;
	localparam ra_t R_A   = 5'd14;
	localparam ra_t R_Q   = 5'd15;
	localparam ra_t R_HQ  = 5'd16;
	localparam ra_t R_A3  = 5'd17;
	localparam ra_t R_T   = 5'd18;
	localparam ra_t R_U   = 5'd19;
	localparam ra_t R_BN  = 5'd20;
	localparam ra_t R_CN  = 5'd21;
	localparam ra_t R_DN  = 5'd22;

	// Load sources.
	localparam ra_t E_PX0  = 5'd0;
	localparam ra_t E_PY0  = 5'd1;
	localparam ra_t E_PX1  = 5'd2;
	localparam ra_t E_PY1  = 5'd3;
	localparam ra_t E_IX   = 5'd4;
	localparam ra_t E_IY   = 5'd5;
	localparam ra_t E_ST   = 5'd6;
	localparam ra_t E_NEW  = 5'd7;
	localparam ra_t E_ZERO = 5'd8;

	// Shift amounts.
	localparam ra_t SH_V  = 5'd0;
	localparam ra_t SH_X  = 5'd1;
	localparam ra_t SH_2X = 5'd2;

	// Quotient destinations.
	localparam ra_t DV_SLOPE = 5'd0;
	localparam ra_t DV_A     = 5'd1;
	localparam ra_t DV_B     = 5'd2;
	localparam ra_t DV_C     = 5'd3;
	localparam ra_t DV_D     = 5'd4;

	// Successor of a program end.
	localparam ra_t NX_LOADA = 5'd0;
	localparam ra_t NX_SEG_I = 5'd1;
	localparam ra_t NX_SEG_L = 5'd2;
	localparam ra_t NX_EMIT  = 5'd3;

	localparam pc_t PC_SLOPE = 7'd0;
	localparam pc_t PC_LOADA = 7'd28;
	localparam pc_t PC_LOADB = 7'd35;
	localparam pc_t PC_SEG   = 7'd42;
	localparam pc_t PC_LAST  = 7'd86;

	typedef struct packed {
		op_t op;
		ra_t dst;
		ra_t sa;
		ra_t sb;
	} uinst_t;

	typedef struct packed {
		logic start;
		op_t  op;
		ra_t  sel;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic busy;
		logic sat;
		logic flag;
	} alu_rsp_t;

	function automatic uinst_t mk(op_t op, ra_t d, ra_t a, ra_t b);
		return '{op: op, dst: d, sa: a, sb: b};
	endfunction

	function automatic uinst_t ucode(pc_t pc);
		uinst_t u;
		u = mk(OP_END, R_X0, R_X0, NX_EMIT);
		unique case (pc)
			// Inner slope at the middle knot.
			7'd0:  u = mk(OP_LD,  R_X0,  E_PX0, R_X0);
			7'd1:  u = mk(OP_LD,  R_Y0,  E_PY0, R_X0);
			7'd2:  u = mk(OP_LD,  R_X1,  E_PX1, R_X0);
			7'd3:  u = mk(OP_LD,  R_Y1,  E_PY1, R_X0);
			7'd4:  u = mk(OP_LD,  R_X2,  E_IX,  R_X0);
			7'd5:  u = mk(OP_LD,  R_Y2,  E_IY,  R_X0);
			7'd6:  u = mk(OP_SUB, R_H,   R_X1,  R_X0);
			7'd7:  u = mk(OP_SUB, R_H2,  R_X2,  R_X1);
			7'd8:  u = mk(OP_SUB, R_DY,  R_Y1,  R_Y0);
			7'd9:  u = mk(OP_SUB, R_DY2, R_Y2,  R_Y1);
			7'd10: u = mk(OP_CHK, R_X0,  R_DY,  R_DY2);
			7'd11: u = mk(OP_ADD, R_T,   R_H,   R_H2);
			7'd12: u = mk(OP_ADD, R_U,   R_T,   R_T);
			7'd13: u = mk(OP_ADD, R_T,   R_U,   R_T);
			7'd14: u = mk(OP_MUL, R_T,   R_T,   R_DY);
			7'd15: u = mk(OP_MUL, R_T,   R_T,   R_DY2);
			7'd16: u = mk(OP_SHL, R_T,   R_T,   SH_V);
			7'd17: u = mk(OP_ADD, R_U,   R_H2,  R_H2);
			7'd18: u = mk(OP_ADD, R_U,   R_U,   R_H);
			7'd19: u = mk(OP_MUL, R_U,   R_U,   R_H);
			7'd20: u = mk(OP_MUL, R_U,   R_U,   R_DY2);
			7'd21: u = mk(OP_ADD, R_A,   R_H,   R_H);
			7'd22: u = mk(OP_ADD, R_A,   R_A,   R_H2);
			7'd23: u = mk(OP_MUL, R_A,   R_A,   R_H2);
			7'd24: u = mk(OP_MUL, R_A,   R_A,   R_DY);
			7'd25: u = mk(OP_ADD, R_U,   R_U,   R_A);
			7'd26: u = mk(OP_DIV, DV_SLOPE, R_T, R_U);
			7'd27: u = mk(OP_END, R_X0,  R_X0,  NX_LOADA);
			// Inner segment operands.
			7'd28: u = mk(OP_LD,  R_X0,  E_PX0, R_X0);
			7'd29: u = mk(OP_LD,  R_Y0,  E_PY0, R_X0);
			7'd30: u = mk(OP_LD,  R_X1,  E_PX1, R_X0);
			7'd31: u = mk(OP_LD,  R_Y1,  E_PY1, R_X0);
			7'd32: u = mk(OP_LD,  R_D0,  E_ST,  R_X0);
			7'd33: u = mk(OP_LD,  R_D1,  E_NEW, R_X0);
			7'd34: u = mk(OP_END, R_X0,  R_X0,  NX_SEG_I);
			// Final segment operands.
			7'd35: u = mk(OP_LD,  R_X0,  E_PX1, R_X0);
			7'd36: u = mk(OP_LD,  R_Y0,  E_PY1, R_X0);
			7'd37: u = mk(OP_LD,  R_X1,  E_IX,  R_X0);
			7'd38: u = mk(OP_LD,  R_Y1,  E_IY,  R_X0);
			7'd39: u = mk(OP_LD,  R_D0,  E_ST,  R_X0);
			7'd40: u = mk(OP_LD,  R_D1,  E_ZERO, R_X0);
			7'd41: u = mk(OP_END, R_X0,  R_X0,  NX_SEG_L);
			// Segment coefficients.
			7'd42: u = mk(OP_SHL, R_Y0,  R_Y0,  SH_V);
			7'd43: u = mk(OP_SHL, R_Y1,  R_Y1,  SH_V);
			7'd44: u = mk(OP_SUB, R_H,   R_X1,  R_X0);
			7'd45: u = mk(OP_SUB, R_DY,  R_Y1,  R_Y0);
			7'd46: u = mk(OP_MUL, R_H2,  R_H,   R_H);
			7'd47: u = mk(OP_MUL, R_H3,  R_H2,  R_H);
			7'd48: u = mk(OP_MUL, R_X02, R_X0,  R_X0);
			7'd49: u = mk(OP_ADD, R_T,   R_D0,  R_D1);
			7'd50: u = mk(OP_MUL, R_A,   R_H,   R_T);
			7'd51: u = mk(OP_ADD, R_T,   R_DY,  R_DY);
			7'd52: u = mk(OP_SUB, R_A,   R_A,   R_T);
			7'd53: u = mk(OP_ADD, R_T,   R_DY,  R_DY);
			7'd54: u = mk(OP_ADD, R_T,   R_T,   R_DY);
			7'd55: u = mk(OP_ADD, R_U,   R_D0,  R_D0);
			7'd56: u = mk(OP_ADD, R_U,   R_U,   R_D1);
			7'd57: u = mk(OP_MUL, R_U,   R_H,   R_U);
			7'd58: u = mk(OP_SUB, R_Q,   R_T,   R_U);
			7'd59: u = mk(OP_MUL, R_HQ,  R_H,   R_Q);
			7'd60: u = mk(OP_ADD, R_A3,  R_A,   R_A);
			7'd61: u = mk(OP_ADD, R_A3,  R_A3,  R_A);
			7'd62: u = mk(OP_MUL, R_T,   R_A3,  R_X0);
			7'd63: u = mk(OP_SUB, R_BN,  R_HQ,  R_T);
			7'd64: u = mk(OP_MUL, R_T,   R_D0,  R_H3);
			7'd65: u = mk(OP_ADD, R_U,   R_HQ,  R_HQ);
			7'd66: u = mk(OP_MUL, R_U,   R_U,   R_X0);
			7'd67: u = mk(OP_SUB, R_CN,  R_T,   R_U);
			7'd68: u = mk(OP_MUL, R_U,   R_A3,  R_X02);
			7'd69: u = mk(OP_ADD, R_CN,  R_CN,  R_U);
			7'd70: u = mk(OP_MUL, R_T,   R_Y0,  R_H3);
			7'd71: u = mk(OP_MUL, R_U,   R_D0,  R_X0);
			7'd72: u = mk(OP_MUL, R_U,   R_U,   R_H3);
			7'd73: u = mk(OP_SUB, R_DN,  R_T,   R_U);
			7'd74: u = mk(OP_MUL, R_U,   R_HQ,  R_X02);
			7'd75: u = mk(OP_ADD, R_DN,  R_DN,  R_U);
			7'd76: u = mk(OP_MUL, R_U,   R_X02, R_X0);
			7'd77: u = mk(OP_MUL, R_U,   R_A,   R_U);
			7'd78: u = mk(OP_SUB, R_DN,  R_DN,  R_U);
			7'd79: u = mk(OP_SHL, R_T,   R_A,   SH_2X);
			7'd80: u = mk(OP_DIV, DV_A,  R_T,   R_H3);
			7'd81: u = mk(OP_SHL, R_T,   R_BN,  SH_X);
			7'd82: u = mk(OP_DIV, DV_B,  R_T,   R_H3);
			7'd83: u = mk(OP_DIV, DV_C,  R_CN,  R_H3);
			7'd84: u = mk(OP_SHL, R_T,   R_H3,  SH_X);
			7'd85: u = mk(OP_DIV, DV_D,  R_DN,  R_T);
			7'd86: u = mk(OP_END, R_X0,  R_X0,  NX_EMIT);
			default: u = mk(OP_END, R_X0, R_X0, NX_EMIT);
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

// ===== sv/pchip_sc_knot_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCHIP knot channel
// One beat carries one knot of a curve.
// ----------------------------------------------------------------------------
interface pchip_sc_knot_if #(
	parameter int KNOT_X_BITS = 16,
	parameter int KNOT_Y_BITS = 32
) ();
	logic                          valid;
	logic                          ready;
	logic        [KNOT_X_BITS-1:0] knot_x;
	logic signed [KNOT_Y_BITS-1:0] knot_y;
	logic                          curve_end;

	modport source (output valid, knot_x, knot_y, curve_end, input ready);
	modport sink (input valid, knot_x, knot_y, curve_end, output ready);
endinterface
`default_nettype wire

// ===== sv/pchip_sc_coef_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCHIP coefficient channel
// One beat carries the cubic coefficients of one segment.
// ----------------------------------------------------------------------------
interface pchip_sc_coef_if #(
	parameter int COEF_BITS = 64
) ();
	logic                        valid;
	logic                        ready;
	logic signed [COEF_BITS-1:0] coef_cubic;
	logic signed [COEF_BITS-1:0] coef_square;
	logic signed [COEF_BITS-1:0] coef_linear;
	logic signed [COEF_BITS-1:0] coef_const;
	logic                        segment_last;
	logic                        saturated;

	modport source (output valid, coef_cubic, coef_square, coef_linear, coef_const,
		segment_last, saturated, input ready);
	modport sink (input valid, coef_cubic, coef_square, coef_linear, coef_const,
		segment_last, saturated, output ready);
endinterface
`default_nettype wire

// ===== sv/pchip_sc_rf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCHIP scratch register file
// Wide scratch memory, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module pchip_sc_rf (
	input  logic                          clk,
	input  logic                          we,
	input  logic [pchip_sc_pkg::RA-1:0]   waddr,
	input  logic [pchip_sc_pkg::DW-1:0]   wdata,
	input  logic [pchip_sc_pkg::RA-1:0]   raddr_a,
	input  logic [pchip_sc_pkg::RA-1:0]   raddr_b,
	output logic [pchip_sc_pkg::DW-1:0]   rdata_a,
	output logic [pchip_sc_pkg::DW-1:0]   rdata_b
);
	import pchip_sc_pkg::*;

	logic [DW-1:0] mem_q [2**RA];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule
`default_nettype wire

// ===== sv/pchip_sc_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCHIP shared arithmetic unit
// Add, subtract, shift and secant check; shift-add multiply and restoring
// divide one bit per cycle; divide rounds and saturates, others are mod 2^DW.
// ----------------------------------------------------------------------------
module pchip_sc_alu #(
	parameter int KNOT_X_BITS = 16,
	parameter int KNOT_Y_BITS = 32,
	parameter int COEF_BITS   = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pchip_sc_pkg::alu_req_t      req,
	input  logic [pchip_sc_pkg::DW-1:0] opa,
	input  logic [pchip_sc_pkg::DW-1:0] opb,
	output pchip_sc_pkg::alu_rsp_t      rsp,
	output logic [pchip_sc_pkg::DW-1:0] res
);
	import pchip_sc_pkg::*;

	localparam int XFRAC = KNOT_X_BITS / 2;
	localparam int VSH   = 24 + XFRAC - KNOT_Y_BITS / 2;

	localparam logic [2:0] A_IDLE = 3'd0;
	localparam logic [2:0] A_MUL  = 3'd1;
	localparam logic [2:0] A_DIV  = 3'd2;
	localparam logic [2:0] A_RND  = 3'd3;
	localparam logic [2:0] A_FIN  = 3'd4;

	localparam logic [63:0] MAX_SLOPE = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX_COEF  = 64'd1 << (COEF_BITS - 1);

	logic [2:0]    st_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] acc_q;   // product, or quotient
	logic [DW-1:0] ma_q;    // shifted multiplicand, or remainder
	logic [DW-1:0] mb_q;    // multiplier, or dividend bits still to come
	logic [DW-1:0] den_q;
	logic          neg_q, dz_q, nz_q, slope_q;
	logic          done_q, sat_q, flag_q;
	logic [DW-1:0] res_q;

	logic [DW-1:0] acc_nx, r_sh, r2;
	logic          ge;
	logic [63:0]   maxmag, q64;
	logic          big_sat;

	assign acc_nx = mb_q[0] ? acc_q + ma_q : acc_q;
	assign r_sh   = {ma_q[DW-2:0], mb_q[DW-1]};
	assign ge     = r_sh >= den_q;
	assign r2     = {ma_q[DW-2:0], 1'b0};
	assign maxmag = slope_q ? MAX_SLOPE : MAX_COEF;
	assign q64    = acc_q[63:0];
	assign big_sat = dz_q || (|acc_q[DW-1:64]) || (neg_q ? (q64 > maxmag) : (q64 >= maxmag));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			flag_q <= 1'b0;
		end else begin
			unique case (st_q)
				A_IDLE: begin
					if (req.start) begin
						unique case (req.op)
							OP_ADD: begin
								res_q  <= opa + opb;
								done_q <= 1'b1;
							end
							OP_SUB: begin
								res_q  <= opa - opb;
								done_q <= 1'b1;
							end
							OP_SHL: begin
								unique case (req.sel)
									SH_V:    res_q <= opa << VSH;
									SH_X:    res_q <= opa << XFRAC;
									SH_2X:   res_q <= opa << (2 * XFRAC);
									default: res_q <= opa;
								endcase
								done_q <= 1'b1;
							end
							OP_CHK: begin
								// Flat or sign-changing secants force a zero slope.
								flag_q <= (opa == '0) || (opb == '0) ||
									(opa[DW-1] != opb[DW-1]);
								done_q <= 1'b1;
							end
							OP_MUL: begin
								acc_q  <= '0;
								ma_q   <= opa;
								mb_q   <= opb;
								cnt_q  <= CW'(DW - 1);
								st_q   <= A_MUL;
								done_q <= 1'b0;
							end
							OP_DIV: begin
								neg_q   <= opa[DW-1] ^ opb[DW-1];
								mb_q    <= opa[DW-1] ? -opa : opa;
								den_q   <= opb[DW-1] ? -opb : opb;
								dz_q    <= (opb == '0);
								nz_q    <= (opa == '0);
								slope_q <= (req.sel == DV_SLOPE);
								acc_q   <= '0;
								ma_q    <= '0;
								cnt_q   <= CW'(DW - 1);
								st_q    <= (opb == '0) ? A_FIN : A_DIV;
								done_q  <= 1'b0;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				A_MUL: begin
					acc_q  <= acc_nx;
					ma_q   <= {ma_q[DW-2:0], 1'b0};
					mb_q   <= {1'b0, mb_q[DW-1:1]};
					cnt_q  <= cnt_q - 1'b1;
					done_q <= (cnt_q == '0);
					if (cnt_q == '0) begin
						res_q <= acc_nx;
						st_q  <= A_IDLE;
					end
				end
				A_DIV: begin
					ma_q   <= ge ? r_sh - den_q : r_sh;
					acc_q  <= {acc_q[DW-2:0], ge};
					mb_q   <= {mb_q[DW-2:0], 1'b0};
					cnt_q  <= cnt_q - 1'b1;
					done_q <= 1'b0;
					if (cnt_q == '0) begin
						st_q <= A_RND;
					end
				end
				A_RND: begin
					// Round to nearest, ties away from zero, on the magnitude.
					if (r2 >= den_q) begin
						acc_q <= acc_q + 1'b1;
					end
					done_q <= 1'b0;
					st_q   <= A_FIN;
				end
				A_FIN: begin
					if (dz_q && nz_q) begin
						res_q <= '0;
					end else if (big_sat) begin
						res_q <= {{(DW-64){1'b0}}, (neg_q ? -maxmag : maxmag - 1'b1)};
					end else begin
						res_q <= {{(DW-64){1'b0}}, (neg_q ? -q64 : q64)};
					end
					sat_q  <= big_sat;
					done_q <= 1'b1;
					st_q   <= A_IDLE;
				end
				default: begin
					done_q <= 1'b0;
					st_q   <= A_IDLE;
				end
			endcase
		end
	end

	assign res       = res_q;
	assign rsp.done  = done_q;
	assign rsp.busy  = (st_q != A_IDLE);
	assign rsp.sat   = sat_q;
	assign rsp.flag  = flag_q;
endmodule
`default_nettype wire

// ===== sv/pchip_segment_coefficients.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCHIP segment coefficients
// Streams curve knots in and absolute-x cubic coefficients of each segment out.
// ----------------------------------------------------------------------------
// Knots are taken one beat at a time and the block is busy until the work for
// that knot is done. The first knot of a curve, and a plain second knot, are
// only stored. A later knot first computes the inner slope and then the
// segment ending at the middle knot; a knot that closes the curve adds the
// final segment. The work is done by the single shared arithmetic unit,
// whose multiplier and divider handle one bit of a 256-bit operand per cycle,
// sixteen products and four quotients per segment, under a microcoded
// sequencer. A finished segment waits in the output register while the next
// one is computed.
// ----------------------------------------------------------------------------
module pchip_segment_coefficients #(
	parameter int KNOT_X_BITS = 16,
	parameter int KNOT_Y_BITS = 32,
	parameter int COEF_BITS   = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	pchip_sc_knot_if.sink    knot,
	pchip_sc_coef_if.source  coef
);
	import pchip_sc_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0] state_q;
	pc_t        pc_q;
	logic [1:0] seen_q;
	logic       end_q, seg_last_q, zero_q, sat_q;
	op_t        op_q;
	ra_t        dst_q;
	ra_t        sel_q;

	logic        [KNOT_X_BITS-1:0] px0_q, px1_q, ix_q;
	logic signed [KNOT_Y_BITS-1:0] py0_q, py1_q, iy_q;
	logic [63:0]                   start_slope_q, new_slope_q;
	logic [COEF_BITS-1:0]          a_q, b_q, c_q, d_q;

	logic                 out_v_q, out_last_q, out_sat_q;
	logic [COEF_BITS-1:0] out_a_q, out_b_q, out_c_q, out_d_q;

	uinst_t        ui;
	logic          rf_we;
	ra_t           rf_wa;
	logic [DW-1:0] rf_wd, rd_a, rd_b, ext_val, alu_res;
	alu_req_t      alu_req;
	alu_rsp_t      alu_rsp;
	logic          knot_acc, out_free, arith_wb;

	assign ui       = ucode(pc_q);
	assign knot_acc = knot.valid && knot.ready;
	assign out_free = !out_v_q || coef.ready;
	assign arith_wb = (state_q == S_WAIT) && alu_rsp.done &&
		(op_q == OP_ADD || op_q == OP_SUB || op_q == OP_MUL || op_q == OP_SHL);

	always_comb begin
		unique case (ui.sa)
			E_PX0:   ext_val = {{(DW-KNOT_X_BITS){1'b0}}, px0_q};
			E_PY0:   ext_val = {{(DW-KNOT_Y_BITS){py0_q[KNOT_Y_BITS-1]}}, py0_q};
			E_PX1:   ext_val = {{(DW-KNOT_X_BITS){1'b0}}, px1_q};
			E_PY1:   ext_val = {{(DW-KNOT_Y_BITS){py1_q[KNOT_Y_BITS-1]}}, py1_q};
			E_IX:    ext_val = {{(DW-KNOT_X_BITS){1'b0}}, ix_q};
			E_IY:    ext_val = {{(DW-KNOT_Y_BITS){iy_q[KNOT_Y_BITS-1]}}, iy_q};
			E_ST:    ext_val = {{(DW-64){start_slope_q[63]}}, start_slope_q};
			E_NEW:   ext_val = {{(DW-64){new_slope_q[63]}}, new_slope_q};
			default: ext_val = '0;
		endcase
	end

	always_comb begin
		if (arith_wb) begin
			rf_we = 1'b1;
			rf_wa = dst_q;
			rf_wd = alu_res;
		end else begin
			rf_we = (state_q == S_FETCH) && (ui.op == OP_LD);
			rf_wa = ui.dst;
			rf_wd = ext_val;
		end
	end

	assign alu_req.start = (state_q == S_EXEC);
	assign alu_req.op    = op_q;
	assign alu_req.sel   = sel_q;

	pchip_sc_rf u_rf (
		.clk     (clk),
		.we      (rf_we),
		.waddr   (rf_wa),
		.wdata   (rf_wd),
		.raddr_a (ui.sa),
		.raddr_b (ui.sb),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	pchip_sc_alu #(
		.KNOT_X_BITS (KNOT_X_BITS),
		.KNOT_Y_BITS (KNOT_Y_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (rd_a),
		.opb    (rd_b),
		.rsp    (alu_rsp),
		.res    (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pc_q          <= PC_SLOPE;
			seen_q        <= 2'd0;
			end_q         <= 1'b0;
			seg_last_q    <= 1'b0;
			zero_q        <= 1'b0;
			sat_q         <= 1'b0;
			op_q          <= OP_END;
			dst_q         <= R_X0;
			sel_q         <= SH_V;
			px0_q         <= '0;
			px1_q         <= '0;
			py0_q         <= '0;
			py1_q         <= '0;
			start_slope_q <= '0;
			out_v_q       <= 1'b0;
		end else begin
			// A beat taken while a new segment is loaded is replaced in S_EMIT.
			if (out_v_q && coef.ready && state_q != S_EMIT) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (knot_acc) begin
						ix_q  <= knot.knot_x;
						iy_q  <= knot.knot_y;
						end_q <= knot.curve_end;
						unique case (seen_q)
							2'd0: begin
								start_slope_q <= '0;
								if (!knot.curve_end) begin
									px1_q  <= knot.knot_x;
									py1_q  <= knot.knot_y;
									seen_q <= 2'd1;
								end
							end
							2'd1: begin
								if (knot.curve_end) begin
									pc_q    <= PC_LOADB;
									state_q <= S_FETCH;
								end else begin
									px0_q  <= px1_q;
									py0_q  <= py1_q;
									px1_q  <= knot.knot_x;
									py1_q  <= knot.knot_y;
									seen_q <= 2'd2;
								end
							end
							default: begin
								pc_q    <= PC_SLOPE;
								state_q <= S_FETCH;
							end
						endcase
					end
				end
				S_FETCH: begin
					unique case (ui.op)
						OP_LD: begin
							pc_q <= pc_q + 1'b1;
						end
						OP_END: begin
							unique case (ui.sb)
								NX_LOADA: begin
									pc_q <= PC_LOADA;
								end
								NX_SEG_I: begin
									seg_last_q <= 1'b0;
									pc_q       <= PC_SEG;
								end
								NX_SEG_L: begin
									// The final segment starts with a clean flag.
									seg_last_q <= 1'b1;
									sat_q      <= 1'b0;
									pc_q       <= PC_SEG;
								end
								default: begin
									state_q <= S_EMIT;
								end
							endcase
						end
						default: begin
							op_q    <= ui.op;
							dst_q   <= ui.dst;
							sel_q   <= (ui.op == OP_SHL) ? ui.sb : ui.dst;
							state_q <= S_EXEC;
						end
					endcase
				end
				S_EXEC: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (alu_rsp.done) begin
						if (op_q == OP_CHK) begin
							zero_q <= alu_rsp.flag;
						end else if (op_q == OP_DIV) begin
							unique case (dst_q)
								DV_SLOPE: begin
									new_slope_q <= zero_q ? 64'd0 : alu_res[63:0];
									sat_q       <= !zero_q && alu_rsp.sat;
								end
								DV_A:    a_q <= alu_res[COEF_BITS-1:0];
								DV_B:    b_q <= alu_res[COEF_BITS-1:0];
								DV_C:    c_q <= alu_res[COEF_BITS-1:0];
								default: d_q <= alu_res[COEF_BITS-1:0];
							endcase
							if (dst_q != DV_SLOPE) begin
								sat_q <= sat_q | alu_rsp.sat;
							end
						end
						pc_q    <= pc_q + 1'b1;
						state_q <= S_FETCH;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_v_q    <= 1'b1;
						out_a_q    <= a_q;
						out_b_q    <= b_q;
						out_c_q    <= c_q;
						out_d_q    <= d_q;
						out_last_q <= seg_last_q;
						out_sat_q  <= sat_q;
						if (seg_last_q) begin
							start_slope_q <= '0;
							seen_q        <= 2'd0;
							state_q       <= S_IDLE;
						end else begin
							start_slope_q <= new_slope_q;
							if (end_q) begin
								pc_q    <= PC_LOADB;
								state_q <= S_FETCH;
							end else begin
								px0_q   <= px1_q;
								py0_q   <= py1_q;
								px1_q   <= ix_q;
								py1_q   <= iy_q;
								seen_q  <= 2'd2;
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign knot.ready        = (state_q == S_IDLE);
	assign coef.valid        = out_v_q;
	assign coef.coef_cubic   = out_a_q;
	assign coef.coef_square  = out_b_q;
	assign coef.coef_linear  = out_c_q;
	assign coef.coef_const   = out_d_q;
	assign coef.segment_last = out_last_q;
	assign coef.saturated    = out_sat_q;

`ifndef ASSERT_OFF
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PC_LAST)
		else $error("microcode counter beyond the program");

	a_alu_free: assert property (@(posedge clk) disable iff (!arst_n)
		alu_req.start |-> !alu_rsp.busy)
		else $error("arithmetic unit started while busy");

	a_seen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q != 2'd3)
		else $error("knot count passed two");

	a_emit_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_v_q && !coef.ready) |=> (state_q == S_EMIT))
		else $error("segment emitted over a beat not yet taken");
`endif
endmodule
`default_nettype wire
